/* hdl/bac_pkg.sv */
// ----------------------------------------------------------------------------
// bac_pkg
// Shared types and constants of the 24-hour BCD alarm clock.
// ----------------------------------------------------------------------------
package bac_pkg;

    localparam int TIME_DIGITS  = 6;
    localparam int ALARM_DIGITS = 4;
    localparam int TPS_W        = 16;

    localparam logic [TPS_W-1:0] TPS_RESET = 16'd1000;

    typedef enum logic [2:0] {
        MODE_TICK       = 3'd0,
        MODE_SET_TIME   = 3'd1,
        MODE_SET_ALARM  = 3'd2,
        MODE_ACTIVATE   = 3'd3,
        MODE_DEACTIVATE = 3'd4,
        MODE_SNOOZE     = 3'd5,
        MODE_CANCEL     = 3'd6,
        MODE_READ       = 3'd7
    } mode_t;

    typedef logic [3:0] digit_t;
    typedef logic [TIME_DIGITS-1:0][3:0]  time_digits_t;
    typedef logic [ALARM_DIGITS-1:0][3:0] alarm_digits_t;

    typedef struct packed {
        mode_t      mode;
        logic [1:0] hour_tens;
        logic [3:0] hour_units;
        logic [2:0] minute_tens;
        logic [3:0] minute_units;
        logic [2:0] second_tens;
        logic [3:0] second_units;
        logic [3:0] snooze_minutes;
    } item_t;

    typedef struct packed {
        logic [1:0]  clock_hour_tens;
        logic [3:0]  clock_hour_units;
        logic [2:0]  clock_minute_tens;
        logic [3:0]  clock_minute_units;
        logic [2:0]  clock_second_tens;
        logic [3:0]  clock_second_units;
        logic        time_valid;
        logic        alarm_active;
        logic        alarm_ringing;
        logic        blink_on;
        logic        event_pulse;
        logic [13:0] set_alarm_bcd;
    } result_t;

endpackage

/* hdl/bac_item_if.sv */
// ----------------------------------------------------------------------------
// bac_item_if
// Request channel into the alarm clock: valid/ready plus command fields.
// ----------------------------------------------------------------------------
interface bac_item_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [1:0] hour_tens;
    logic [3:0] hour_units;
    logic [2:0] minute_tens;
    logic [3:0] minute_units;
    logic [2:0] second_tens;
    logic [3:0] second_units;
    logic [3:0] snooze_minutes;

    modport source (
        output valid, mode, hour_tens, hour_units, minute_tens, minute_units,
               second_tens, second_units, snooze_minutes,
        input  ready
    );

    modport sink (
        input  valid, mode, hour_tens, hour_units, minute_tens, minute_units,
               second_tens, second_units, snooze_minutes,
        output ready
    );
endinterface

/* hdl/bac_result_if.sv */
// ----------------------------------------------------------------------------
// bac_result_if
// Result channel out of the alarm clock: valid/ready plus clock status.
// ----------------------------------------------------------------------------
interface bac_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  clock_hour_tens;
    logic [3:0]  clock_hour_units;
    logic [2:0]  clock_minute_tens;
    logic [3:0]  clock_minute_units;
    logic [2:0]  clock_second_tens;
    logic [3:0]  clock_second_units;
    logic        time_valid;
    logic        alarm_active;
    logic        alarm_ringing;
    logic        blink_on;
    logic        event_pulse;
    logic [13:0] set_alarm_bcd;

    modport source (
        output valid, clock_hour_tens, clock_hour_units, clock_minute_tens,
               clock_minute_units, clock_second_tens, clock_second_units,
               time_valid, alarm_active, alarm_ringing, blink_on, event_pulse,
               set_alarm_bcd,
        input  ready
    );

    modport sink (
        input  valid, clock_hour_tens, clock_hour_units, clock_minute_tens,
               clock_minute_units, clock_second_tens, clock_second_units,
               time_valid, alarm_active, alarm_ringing, blink_on, event_pulse,
               set_alarm_bcd,
        output ready
    );
endinterface

/* hdl/bac_core.sv */
// ----------------------------------------------------------------------------
// bac_core
// Clock and alarm state with the combinational step logic for one command.
// ----------------------------------------------------------------------------
module bac_core
    import bac_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  item_t            item,
    input  logic             cfg_we,
    input  logic [TPS_W-1:0] cfg_wdata,
    output result_t          result
);

    localparam digit_t UNIT_LIMIT = 4'd10;
    localparam digit_t TENS_LIMIT = 4'd6;
    localparam digit_t WRAP_TENS  = 4'd2;
    localparam digit_t WRAP_UNITS = 4'd4;

    time_digits_t     time_reg, time_next;
    alarm_digits_t    alarm_reg, alarm_next;
    alarm_digits_t    walarm_reg, walarm_next;
    logic [TPS_W-1:0] ssc_reg, ssc_next;
    logic [TPS_W-1:0] tps_reg;
    logic             tset_reg, tset_next;
    logic             aset_reg, aset_next;
    logic             armed_reg, armed_next;
    logic             ring_reg, ring_next;
    logic             event_next;

    function automatic alarm_digits_t snooze_add(alarm_digits_t w, logic [3:0] mins);
        logic [4:0]    u;
        alarm_digits_t r;
        r = w;
        u = {1'b0, w[3]} + {1'b0, mins};
        if (u >= 5'd30) begin
            r[2] = r[2] + 4'd1;
            r[3] = 4'(u - 5'd30);
        end else if (u >= 5'd20) begin
            r[2] = r[2] + 4'd1;
            r[3] = 4'(u - 5'd20);
        end else if (u >= 5'd10) begin
            r[2] = r[2] + 4'd1;
            r[3] = 4'(u - 5'd10);
        end else begin
            r[3] = u[3:0];
        end
        if (r[2] >= 4'd12) begin
            r[1] = r[1] + 4'd1;
            r[2] = r[2] - 4'd12;
        end else if (r[2] >= TENS_LIMIT) begin
            r[1] = r[1] + 4'd1;
            r[2] = r[2] - TENS_LIMIT;
        end
        if (r[1] >= UNIT_LIMIT) begin
            r[0] = r[0] + 4'd1;
            r[1] = r[1] - UNIT_LIMIT;
        end
        if (r[1] >= WRAP_UNITS && r[0] >= WRAP_TENS) begin
            r[1] = '0;
            r[0] = '0;
        end
        return r;
    endfunction

    always_comb
    begin
        logic match;
        time_next   = time_reg;
        alarm_next  = alarm_reg;
        walarm_next = walarm_reg;
        ssc_next    = ssc_reg;
        tset_next   = tset_reg;
        aset_next   = aset_reg;
        armed_next  = armed_reg;
        ring_next   = ring_reg;
        event_next  = 1'b0;
        match       = 1'b1;
        case (item.mode)
            MODE_TICK:
            begin
                ssc_next = ssc_reg + 16'd1;
                if (ssc_next >= tps_reg) begin
                    ssc_next     = '0;
                    time_next[5] = time_next[5] + 4'd1;
                end
                // seconds -> minutes -> hours ripple
                for (int i = TIME_DIGITS - 1; i >= 1; i--) begin
                    if (time_next[i] >= ((i % 2 == 1) ? UNIT_LIMIT : TENS_LIMIT)) begin
                        time_next[i]   = '0;
                        time_next[i-1] = time_next[i-1] + 4'd1;
                    end
                end
                if (time_next[0] == WRAP_TENS && time_next[1] == WRAP_UNITS) begin
                    time_next[0] = '0;
                    time_next[1] = '0;
                end
                for (int i = 0; i < ALARM_DIGITS; i++) begin
                    if (walarm_reg[i] != time_next[i])
                        match = 1'b0;
                end
                if (match) begin
                    event_next = 1'b1;
                    if (armed_reg)
                        ring_next = 1'b1;
                end
            end
            MODE_SET_TIME:
            begin
                time_next[0] = {2'b00, item.hour_tens};
                time_next[1] = item.hour_units;
                time_next[2] = {1'b0, item.minute_tens};
                time_next[3] = item.minute_units;
                time_next[4] = {1'b0, item.second_tens};
                time_next[5] = item.second_units;
                tset_next    = 1'b1;
            end
            MODE_SET_ALARM:
            begin
                alarm_next[0] = {2'b00, item.hour_tens};
                alarm_next[1] = item.hour_units;
                alarm_next[2] = {1'b0, item.minute_tens};
                alarm_next[3] = item.minute_units;
                walarm_next   = alarm_next;
                aset_next     = 1'b1;
            end
            MODE_ACTIVATE:
            begin
                if (aset_reg)
                    armed_next = 1'b1;
            end
            MODE_DEACTIVATE:
            begin
                armed_next = 1'b0;
                ring_next  = 1'b0;
                event_next = 1'b1;
            end
            MODE_SNOOZE:
            begin
                if (ring_reg) begin
                    ring_next   = 1'b0;
                    event_next  = 1'b1;
                    walarm_next = snooze_add(walarm_reg, item.snooze_minutes);
                end
            end
            MODE_CANCEL:
            begin
                if (ring_reg) begin
                    ring_next   = 1'b0;
                    event_next  = 1'b1;
                    walarm_next = alarm_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        result.clock_hour_tens    = time_next[0][1:0];
        result.clock_hour_units   = time_next[1];
        result.clock_minute_tens  = time_next[2][2:0];
        result.clock_minute_units = time_next[3];
        result.clock_second_tens  = time_next[4][2:0];
        result.clock_second_units = time_next[5];
        result.time_valid         = tset_next;
        result.alarm_active       = armed_next;
        result.alarm_ringing      = ring_next;
        result.blink_on           = (ssc_next < (tps_reg >> 1));
        result.event_pulse        = event_next;
        result.set_alarm_bcd      = {alarm_next[0][1:0], alarm_next[1],
                                     alarm_next[2], alarm_next[3]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            time_reg   <= '0;
            alarm_reg  <= '0;
            walarm_reg <= '0;
            ssc_reg    <= '0;
            tps_reg    <= TPS_RESET;
            tset_reg   <= 1'b0;
            aset_reg   <= 1'b0;
            armed_reg  <= 1'b0;
            ring_reg   <= 1'b0;
        end else begin
            if (cfg_we)
                tps_reg <= cfg_wdata;
            if (step_en) begin
                time_reg   <= time_next;
                alarm_reg  <= alarm_next;
                walarm_reg <= walarm_next;
                ssc_reg    <= ssc_next;
                tset_reg   <= tset_next;
                aset_reg   <= aset_next;
                armed_reg  <= armed_next;
                ring_reg   <= ring_next;
            end
        end
    end

endmodule

/* hdl/bcd_alarm_clock_24h.sv */
// ----------------------------------------------------------------------------
// bcd_alarm_clock_24h
// 24-hour BCD clock with one alarm, snooze and cancel.
// ----------------------------------------------------------------------------
// Usage:
//   item_in    valid/ready request channel, one command per request (tick,
//              set time, set alarm, activate, deactivate, snooze, cancel,
//              read only).
//   result_out valid/ready channel, one result per request: clock digits,
//              flags, blink and event pulse after the command.
//   cfg_we/cfg_wdata write ticks per second; write only while idle.
// Throughput: one request per cycle while the receiver keeps result_out.ready
//   high; the step is a single pass through the core logic between the
//   request register and the result register.
// Reset clears the time, the alarm and all flags; ticks per second = 1000.
// A stalled receiver holds the result; one more request is still taken into
//   the request register, after which item_in.ready drops until the result
//   is taken.
// ----------------------------------------------------------------------------
module bcd_alarm_clock_24h
    import bac_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    bac_item_if.sink         item_in,
    bac_result_if.source     result_out,
    input  logic             cfg_we,
    input  logic [TPS_W-1:0] cfg_wdata
);

    item_t   item_reg;
    logic    item_valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    result_valid_reg;
    logic    out_load;
    logic    in_take;

    assign out_load      = item_valid_reg && (!result_valid_reg || result_out.ready);
    assign item_in.ready = !item_valid_reg || out_load;
    assign in_take       = item_in.valid && item_in.ready;

    bac_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (out_load),
        .item      (item_reg),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .result    (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end else begin
            if (in_take)
                item_valid_reg <= 1'b1;
            else if (out_load)
                item_valid_reg <= 1'b0;
            if (out_load)
                result_valid_reg <= 1'b1;
            else if (result_out.ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take) begin
            item_reg.mode           <= mode_t'(item_in.mode);
            item_reg.hour_tens      <= item_in.hour_tens;
            item_reg.hour_units     <= item_in.hour_units;
            item_reg.minute_tens    <= item_in.minute_tens;
            item_reg.minute_units   <= item_in.minute_units;
            item_reg.second_tens    <= item_in.second_tens;
            item_reg.second_units   <= item_in.second_units;
            item_reg.snooze_minutes <= item_in.snooze_minutes;
        end
        if (out_load)
            result_reg <= result_next;
    end

    assign result_out.valid              = result_valid_reg;
    assign result_out.clock_hour_tens    = result_reg.clock_hour_tens;
    assign result_out.clock_hour_units   = result_reg.clock_hour_units;
    assign result_out.clock_minute_tens  = result_reg.clock_minute_tens;
    assign result_out.clock_minute_units = result_reg.clock_minute_units;
    assign result_out.clock_second_tens  = result_reg.clock_second_tens;
    assign result_out.clock_second_units = result_reg.clock_second_units;
    assign result_out.time_valid         = result_reg.time_valid;
    assign result_out.alarm_active       = result_reg.alarm_active;
    assign result_out.alarm_ringing      = result_reg.alarm_ringing;
    assign result_out.blink_on           = result_reg.blink_on;
    assign result_out.event_pulse        = result_reg.event_pulse;
    assign result_out.set_alarm_bcd      = result_reg.set_alarm_bcd;

    // ringing is only ever set while armed, and disarm clears both
    a_ring_armed: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.alarm_ringing |-> result_reg.alarm_active)
        else $error("ringing without armed alarm");

    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !item_in.ready |-> item_valid_reg && result_valid_reg && !result_out.ready)
        else $error("request stalled with room in the pipe");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> result_valid_reg)
        else $error("stepped request lost its result");

    a_take_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> item_valid_reg)
        else $error("accepted request dropped");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 24-hour BCD alarm clock.
// A table of directed requests (reset state, extreme times, alarm, snooze
// and cancel corners, odd digits, tick-rate extremes) runs first. Random
// alarm scenarios, rollover runs and noise follow under several tick rates
// and several idle/stall mixes. Every result is checked field by field
// against the table's expected result or an in-bench model of the clock.
// ----------------------------------------------------------------------------
module tb;
    import bac_pkg::*;

    localparam int LIMIT = 200000;

    typedef struct {
        bit         cfg;
        logic [15:0] rate;
        item_t      it;
        bit         typed;
        result_t    want;
    } step_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [TPS_W-1:0] cfg_wdata;

    bac_item_if   item_in ();
    bac_result_if result_out ();

    bcd_alarm_clock_24h u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_in),
        .result_out (result_out),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    // model state
    logic [3:0]  now_d [6]    = '{default: 4'd0};
    logic [3:0]  alarm_d [4]  = '{default: 4'd0};
    logic [3:0]  snooze_d [4] = '{default: 4'd0};
    logic [15:0] sub_count    = '0;
    logic [15:0] tick_rate    = TPS_RESET;
    logic        time_ok      = 1'b0;
    logic        alarm_ok     = 1'b0;
    logic        armed        = 1'b0;
    logic        ringing      = 1'b0;

    result_t due_displays [$];
    int      idle_pct  = 0;
    int      stall_pct = 0;
    int      issued    = 0;
    int      cycles    = 0;
    bit      failed    = 1'b0;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic result_t clock_step(item_t it);
        result_t r;
        logic hit;
        int unsigned u;
        hit = 1'b0;
        case (it.mode)
            MODE_TICK:
            begin
                sub_count = sub_count + 16'd1;
                if (sub_count >= tick_rate)
                begin
                    sub_count = '0;
                    now_d[5] = now_d[5] + 4'd1;
                end
                for (int p = 5; p >= 1; p--)
                begin
                    if (now_d[p] >= ((p % 2 == 1) ? 10 : 6))
                    begin
                        now_d[p] = 4'd0;
                        now_d[p-1] = now_d[p-1] + 4'd1;
                    end
                end
                if (now_d[0] == 4'd2 && now_d[1] == 4'd4)
                begin
                    now_d[0] = 4'd0;
                    now_d[1] = 4'd0;
                end
                if (snooze_d[0] == now_d[0] && snooze_d[1] == now_d[1] &&
                    snooze_d[2] == now_d[2] && snooze_d[3] == now_d[3])
                begin
                    hit = 1'b1;
                    if (armed)
                        ringing = 1'b1;
                end
            end
            MODE_SET_TIME:
            begin
                now_d[0] = {2'b00, it.hour_tens};
                now_d[1] = it.hour_units;
                now_d[2] = {1'b0, it.minute_tens};
                now_d[3] = it.minute_units;
                now_d[4] = {1'b0, it.second_tens};
                now_d[5] = it.second_units;
                time_ok = 1'b1;
            end
            MODE_SET_ALARM:
            begin
                alarm_d[0] = {2'b00, it.hour_tens};
                alarm_d[1] = it.hour_units;
                alarm_d[2] = {1'b0, it.minute_tens};
                alarm_d[3] = it.minute_units;
                snooze_d = alarm_d;
                alarm_ok = 1'b1;
            end
            MODE_ACTIVATE:
            begin
                if (alarm_ok)
                    armed = 1'b1;
            end
            MODE_DEACTIVATE:
            begin
                armed = 1'b0;
                ringing = 1'b0;
                hit = 1'b1;
            end
            MODE_SNOOZE:
            begin
                if (ringing)
                begin
                    ringing = 1'b0;
                    hit = 1'b1;
                    u = snooze_d[3] + it.snooze_minutes;
                    snooze_d[3] = 4'(u);
                    if (u >= 10)
                    begin
                        snooze_d[2] = snooze_d[2] + 4'd1;
                        snooze_d[3] = 4'(u % 10);
                    end
                    if (snooze_d[2] >= 6)
                    begin
                        snooze_d[1] = snooze_d[1] + 4'd1;
                        snooze_d[2] = 4'(snooze_d[2] % 6);
                    end
                    if (snooze_d[1] >= 10)
                    begin
                        snooze_d[0] = snooze_d[0] + 4'd1;
                        snooze_d[1] = 4'(snooze_d[1] % 10);
                    end
                    if (snooze_d[1] >= 4 && snooze_d[0] >= 2)
                    begin
                        snooze_d[1] = 4'd0;
                        snooze_d[0] = 4'd0;
                    end
                end
            end
            MODE_CANCEL:
            begin
                if (ringing)
                begin
                    ringing = 1'b0;
                    hit = 1'b1;
                    snooze_d = alarm_d;
                end
            end
            default: ;
        endcase
        r.clock_hour_tens    = now_d[0][1:0];
        r.clock_hour_units   = now_d[1];
        r.clock_minute_tens  = now_d[2][2:0];
        r.clock_minute_units = now_d[3];
        r.clock_second_tens  = now_d[4][2:0];
        r.clock_second_units = now_d[5];
        r.time_valid         = time_ok;
        r.alarm_active       = armed;
        r.alarm_ringing      = ringing;
        r.blink_on           = (sub_count < (tick_rate >> 1));
        r.event_pulse        = hit;
        r.set_alarm_bcd      = {alarm_d[0][1:0], alarm_d[1], alarm_d[2], alarm_d[3]};
        return r;
    endfunction

    function automatic item_t put(mode_t m, int ht, int hu, int mt, int mu,
                                  int st, int su, int sn);
        item_t it;
        it.mode           = m;
        it.hour_tens      = 2'(ht);
        it.hour_units     = 4'(hu);
        it.minute_tens    = 3'(mt);
        it.minute_units   = 4'(mu);
        it.second_tens    = 3'(st);
        it.second_units   = 4'(su);
        it.snooze_minutes = 4'(sn);
        return it;
    endfunction

    function automatic item_t noise();
        logic [31:0] raw;
        logic [$bits(item_t)-1:0] bits;
        raw  = $urandom;
        bits = raw[$bits(item_t)-1:0];
        return item_t'(bits);
    endfunction

    function automatic item_t with_mode(mode_t m);
        item_t it;
        it = noise();
        it.mode = m;
        return it;
    endfunction

    function automatic item_t rand_hhmm(mode_t m);
        int ht;
        ht = $urandom_range(2);
        return put(m, ht, (ht == 2) ? $urandom_range(3) : $urandom_range(9),
                   $urandom_range(5), $urandom_range(9), $urandom_range(5),
                   $urandom_range(9), $urandom_range(9));
    endfunction

    function automatic result_t shown(int h1, int h0, int m1, int m0, int s1, int s0,
                                      bit tv, bit act, bit rng, bit blk, bit ev,
                                      int bcd);
        result_t r;
        r.clock_hour_tens    = 2'(h1);
        r.clock_hour_units   = 4'(h0);
        r.clock_minute_tens  = 3'(m1);
        r.clock_minute_units = 4'(m0);
        r.clock_second_tens  = 3'(s1);
        r.clock_second_units = 4'(s0);
        r.time_valid         = tv;
        r.alarm_active       = act;
        r.alarm_ringing      = rng;
        r.blink_on           = blk;
        r.event_pulse        = ev;
        r.set_alarm_bcd      = 14'(bcd);
        return r;
    endfunction

    function automatic step_row_t cmd_row(item_t it, bit typed = 1'b0,
                                          result_t want = '0);
        step_row_t row;
        row.cfg   = 1'b0;
        row.rate  = '0;
        row.it    = it;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    function automatic step_row_t rate_row(logic [15:0] v);
        step_row_t row;
        row = cmd_row(put(MODE_READ, 0, 0, 0, 0, 0, 0, 0));
        row.cfg  = 1'b1;
        row.rate = v;
        return row;
    endfunction

    task automatic issue(item_t it, bit typed = 1'b0, result_t want = '0);
        int gap;
        result_t p;
        gap = 0;
        while (gap < 8 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap != 0)
        begin
            item_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_in.valid          <= 1'b1;
        item_in.mode           <= it.mode;
        item_in.hour_tens      <= it.hour_tens;
        item_in.hour_units     <= it.hour_units;
        item_in.minute_tens    <= it.minute_tens;
        item_in.minute_units   <= it.minute_units;
        item_in.second_tens    <= it.second_tens;
        item_in.second_units   <= it.second_units;
        item_in.snooze_minutes <= it.snooze_minutes;
        @(posedge clk);
        while (!item_in.ready)
            @(posedge clk);
        p = clock_step(it);
        due_displays.push_back(typed ? want : p);
        issued++;
    endtask

    task automatic ticks(int k);
        repeat (k) issue(with_mode(MODE_TICK));
    endtask

    task automatic set_tick_rate(logic [15:0] v);
        item_in.valid <= 1'b0;
        @(posedge clk);
        while (due_displays.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        tick_rate = v;
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failed = 1'b1;
        end
    endtask

    result_t head;

    always @(posedge clk)
    begin
        if (rst_n && result_out.valid && result_out.ready)
        begin
            if (due_displays.size() == 0)
            begin
                $error("result with no request pending");
                failed = 1'b1;
            end
            else
            begin
                head = due_displays.pop_front();
                check_field("clock_hour_tens", 16'(head.clock_hour_tens),
                            16'(result_out.clock_hour_tens));
                check_field("clock_hour_units", 16'(head.clock_hour_units),
                            16'(result_out.clock_hour_units));
                check_field("clock_minute_tens", 16'(head.clock_minute_tens),
                            16'(result_out.clock_minute_tens));
                check_field("clock_minute_units", 16'(head.clock_minute_units),
                            16'(result_out.clock_minute_units));
                check_field("clock_second_tens", 16'(head.clock_second_tens),
                            16'(result_out.clock_second_tens));
                check_field("clock_second_units", 16'(head.clock_second_units),
                            16'(result_out.clock_second_units));
                check_field("time_valid", 16'(head.time_valid),
                            16'(result_out.time_valid));
                check_field("alarm_active", 16'(head.alarm_active),
                            16'(result_out.alarm_active));
                check_field("alarm_ringing", 16'(head.alarm_ringing),
                            16'(result_out.alarm_ringing));
                check_field("blink_on", 16'(head.blink_on),
                            16'(result_out.blink_on));
                check_field("event_pulse", 16'(head.event_pulse),
                            16'(result_out.event_pulse));
                check_field("set_alarm_bcd", 16'(head.set_alarm_bcd),
                            16'(result_out.set_alarm_bcd));
            end
        end
        result_out.ready <= ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        step_row_t plan [$];
        logic [15:0] seg_rate [8];
        int target;
        int pick;
        int v;
        int ht;
        int hu;
        int mt;
        int mu;
        item_t it;

        item_in.valid          <= 1'b0;
        item_in.mode           <= MODE_READ;
        item_in.hour_tens      <= '0;
        item_in.hour_units     <= '0;
        item_in.minute_tens    <= '0;
        item_in.minute_units   <= '0;
        item_in.second_tens    <= '0;
        item_in.second_units   <= '0;
        item_in.snooze_minutes <= '0;
        cfg_we                 <= 1'b0;
        cfg_wdata              <= '0;
        rst_n                  <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset state, ignored commands, extreme time, wrap into a ringing alarm
        plan.push_back(cmd_row(put(MODE_READ, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                               shown(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0)));
        plan.push_back(cmd_row(put(MODE_ACTIVATE, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                               shown(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0)));
        plan.push_back(cmd_row(put(MODE_SNOOZE, 0, 0, 0, 0, 0, 0, 9), 1'b1,
                               shown(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0)));
        plan.push_back(cmd_row(put(MODE_CANCEL, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                               shown(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0)));
        plan.push_back(cmd_row(put(MODE_DEACTIVATE, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                               shown(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0)));
        plan.push_back(cmd_row(put(MODE_SET_TIME, 2, 3, 5, 9, 5, 9, 0), 1'b1,
                               shown(2, 3, 5, 9, 5, 9, 1, 0, 0, 1, 0, 0)));
        plan.push_back(cmd_row(put(MODE_SET_ALARM, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                               shown(2, 3, 5, 9, 5, 9, 1, 0, 0, 1, 0, 0)));
        plan.push_back(cmd_row(put(MODE_ACTIVATE, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                               shown(2, 3, 5, 9, 5, 9, 1, 1, 0, 1, 0, 0)));
        plan.push_back(rate_row(16'd1));
        plan.push_back(cmd_row(put(MODE_TICK, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                               shown(0, 0, 0, 0, 0, 0, 1, 1, 1, 0, 1, 0)));
        plan.push_back(cmd_row(put(MODE_SNOOZE, 0, 0, 0, 0, 0, 0, 9), 1'b1,
                               shown(0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 1, 0)));
        plan.push_back(cmd_row(put(MODE_TICK, 0, 0, 0, 0, 0, 0, 0)));
        plan.push_back(cmd_row(put(MODE_SET_TIME, 0, 0, 0, 9, 5, 8, 0)));
        plan.push_back(cmd_row(put(MODE_TICK, 0, 0, 0, 0, 0, 0, 0)));
        plan.push_back(cmd_row(put(MODE_TICK, 0, 0, 0, 0, 0, 0, 0)));
        plan.push_back(cmd_row(put(MODE_CANCEL, 0, 0, 0, 0, 0, 0, 0)));
        // snooze across midnight
        plan.push_back(cmd_row(put(MODE_SET_ALARM, 2, 3, 5, 9, 0, 0, 0)));
        plan.push_back(cmd_row(put(MODE_SET_TIME, 2, 3, 5, 8, 5, 9, 0)));
        plan.push_back(cmd_row(put(MODE_TICK, 0, 0, 0, 0, 0, 0, 0)));
        plan.push_back(cmd_row(put(MODE_SNOOZE, 0, 0, 0, 0, 0, 0, 9)));
        plan.push_back(cmd_row(put(MODE_DEACTIVATE, 0, 0, 0, 0, 0, 0, 0)));
        // digits beyond BCD range
        plan.push_back(cmd_row(put(MODE_SET_TIME, 3, 15, 7, 15, 7, 15, 15)));
        plan.push_back(cmd_row(put(MODE_TICK, 0, 0, 0, 0, 0, 0, 0)));
        plan.push_back(cmd_row(put(MODE_SET_ALARM, 3, 15, 7, 15, 7, 15, 15)));
        plan.push_back(rate_row(16'd0));
        plan.push_back(cmd_row(put(MODE_TICK, 0, 0, 0, 0, 0, 0, 0)));
        plan.push_back(cmd_row(put(MODE_TICK, 3, 15, 7, 15, 7, 15, 15)));
        plan.push_back(rate_row(16'hFFFF));
        plan.push_back(cmd_row(put(MODE_TICK, 0, 0, 0, 0, 0, 0, 0)));
        plan.push_back(cmd_row(put(MODE_READ, 3, 15, 7, 15, 7, 15, 15)));

        foreach (plan[i])
        begin
            if (plan[i].cfg)
                set_tick_rate(plan[i].rate);
            else
                issue(plan[i].it, plan[i].typed, plan[i].want);
        end

        seg_rate = '{16'd1, 16'd2, 16'd3, 16'd1, 16'd7, 16'd0, 16'd1, 16'hFFFF};
        for (int seg = 0; seg < 8; seg++)
        begin
            set_tick_rate(seg_rate[seg]);
            case (seg % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 55; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 55; end
                default: begin idle_pct = 11; stall_pct = 11; end
            endcase
            target = issued + 225;
            while (issued < target)
            begin
                pick = $urandom_range(99);
                if (pick < 55)
                begin
                    if ($urandom_range(4) != 0)
                        issue(rand_hhmm(MODE_SET_ALARM));
                    if ($urandom_range(4) != 0)
                        issue(with_mode(MODE_ACTIVATE));
                    // land inside the alarm minute, or just before it
                    it = rand_hhmm(MODE_SET_TIME);
                    it.hour_tens    = snooze_d[0][1:0];
                    it.hour_units   = snooze_d[1];
                    it.minute_tens  = snooze_d[2][2:0];
                    it.minute_units = snooze_d[3];
                    if (snooze_d[3] != 0 && $urandom_range(2) == 0)
                    begin
                        it.minute_units = snooze_d[3] - 4'd1;
                        it.second_tens  = 3'd5;
                        it.second_units = 4'($urandom_range(7, 9));
                    end
                    issue(it);
                    ticks($urandom_range(1, 8));
                    v = $urandom_range(5);
                    case (v)
                        0, 1:
                        begin
                            it = with_mode(MODE_SNOOZE);
                            it.snooze_minutes = 4'(($urandom_range(7) == 0) ?
                                                   $urandom_range(15) : $urandom_range(9));
                            issue(it);
                        end
                        2: issue(with_mode(MODE_CANCEL));
                        3: issue(with_mode(MODE_DEACTIVATE));
                        4: issue(with_mode(MODE_ACTIVATE));
                        default: issue(with_mode(MODE_READ));
                    endcase
                    ticks($urandom_range(5));
                end
                else if (pick < 75)
                begin
                    v  = $urandom_range(2);
                    ht = $urandom_range(2);
                    hu = (ht == 2) ? $urandom_range(3) : $urandom_range(9);
                    mt = (v >= 1) ? 5 : $urandom_range(5);
                    mu = 9;
                    if (v == 2)
                    begin
                        ht = 2;
                        hu = 3;
                    end
                    issue(put(MODE_SET_TIME, ht, hu, mt, mu, 5, $urandom_range(7, 9),
                              $urandom_range(9)));
                    ticks($urandom_range(1, 6));
                end
                else
                begin
                    repeat ($urandom_range(1, 4)) issue(noise());
                end
            end
        end

        item_in.valid <= 1'b0;
        while (due_displays.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        if (!failed)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
hdl/bac_pkg.sv
hdl/bac_item_if.sv
hdl/bac_result_if.sv
hdl/bac_core.sv
hdl/bcd_alarm_clock_24h.sv
bench/tb.sv
